FILE: src/tbu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the triangle tangent/bitangent unit.
// No dependencies; every other file imports this package.
package tbu_pkg;

  localparam int OUT_FRAC_BITS_DEF = 14;
  localparam int QUEUE_DEPTH       = 2;
  localparam int IN_W              = 160;
  localparam int OUT_W             = 96;
  localparam int USER_W            = 3;

  localparam logic [1:0] LAST_CORNER = 2'd2;

  typedef logic signed [32:0] delta_t;

  // One corner as it sits in the slave tdata word, pos_x in the lowest bits.
  typedef struct packed {
    logic [31:0] v;
    logic [31:0] u;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } corner_t;

  // Edge and texture deltas of one triangle; index 0 is the x component.
  typedef struct packed {
    delta_t [2:0] e1;
    delta_t [2:0] e2;
    delta_t       x1;
    delta_t       x2;
    delta_t       y1;
    delta_t       y2;
  } tbu_tri_t;

  function automatic delta_t sub33(input logic [31:0] a, input logic [31:0] b);
    sub33 = $signed({a[31], a}) - $signed({b[31], b});
  endfunction

endpackage

FILE: src/triangle_tangent_bitangent_unit.sv
`timescale 1ns / 1ps
// Top level of the triangle tangent/bitangent unit.
// Depends on tbu_pkg, tbu_front, tbu_queue and tbu_back.
//
//  Channel  Dir  Carries
//  s_*      in   one corner per transfer: position and texture coordinate
//  m_*      out  three transfers per triangle: unit tangent and bitangent
//
// The front end holds two corners and, on the third, hands the triangle
// deltas to a two-entry queue. The back end runs one shared multiplier,
// square root and divider per triangle; a degenerate triangle skips the
// normalization and emits zero vectors.
// rst is synchronous; a stalled master side backs up through the queue.
module triangle_tangent_bitangent_unit
  import tbu_pkg::*;
#(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
  output logic [OUT_W-1:0]  m_tdata,
  // degenerate, corner_slot
  output logic [USER_W-1:0] m_tuser,
  output logic              m_tlast
);

  logic     push;
  tbu_tri_t push_data;
  logic     q_full;
  logic     q_empty;
  logic     pop;
  tbu_tri_t q_head;

  tbu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  tbu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  tbu_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: src/tbu_front.sv
`timescale 1ns / 1ps
// Front end: takes corners, holds the first two, forms the triangle deltas.
// Depends on tbu_pkg.
module tbu_front
  import tbu_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,
  output logic            push,
  output tbu_tri_t        push_data,
  input  logic            q_full
);

  logic [1:0] corner_count;
  corner_t    held [2];
  corner_t    cur;
  logic       accept;

  assign cur      = s_tdata;
  // Only the completing corner needs room in the queue.
  assign s_tready = (corner_count != LAST_CORNER) || !q_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && (corner_count == LAST_CORNER);

  always_comb begin
    push_data.e1[0] = sub33(held[1].x, held[0].x);
    push_data.e1[1] = sub33(held[1].y, held[0].y);
    push_data.e1[2] = sub33(held[1].z, held[0].z);
    push_data.e2[0] = sub33(cur.x, held[0].x);
    push_data.e2[1] = sub33(cur.y, held[0].y);
    push_data.e2[2] = sub33(cur.z, held[0].z);
    push_data.x1    = sub33(held[1].u, held[0].u);
    push_data.x2    = sub33(cur.u, held[0].u);
    push_data.y1    = sub33(held[1].v, held[0].v);
    push_data.y2    = sub33(cur.v, held[0].v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= '0;
    end else if (accept) begin
      if (corner_count == LAST_CORNER) begin
        corner_count <= '0;
      end else begin
        corner_count <= corner_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && corner_count != LAST_CORNER) begin
      held[corner_count[0]] <= cur;
    end
  end

endmodule

FILE: src/tbu_queue.sv
`timescale 1ns / 1ps
// Short queue of triangle records between the front and back ends.
// Depends on tbu_pkg.
module tbu_queue
  import tbu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  tbu_tri_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output tbu_tri_t head
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  tbu_tri_t     entries [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   used;

  assign full  = (used == (PW+1)'(QUEUE_DEPTH));
  assign empty = (used == '0);
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PW'(1);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      if (push && !pop) begin
        used <= used + (PW+1)'(1);
      end else if (pop && !push) begin
        used <= used - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

endmodule

FILE: src/tbu_back.sv
`timescale 1ns / 1ps
// Back end: cross products on one shared multiplier, then, if not degenerate,
// per vector: normalizing shift, squares summed, square root, three divisions.
// Depends on tbu_pkg.
module tbu_back
  import tbu_pkg::*;
#(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  tbu_tri_t          q_head,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  output logic [USER_W-1:0] m_tuser,
  output logic              m_tlast
);

  localparam int QW = OUT_FRAC_BITS + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CHECK, S_LOAD, S_SHIFT, S_SQ, S_SQRT, S_DINIT, S_DIV,
    S_STORE, S_EMIT
  } state_t;

  state_t               state;
  tbu_tri_t             tri_r;
  logic [5:0]           cnt;
  logic signed [65:0]   prod;
  logic signed [65:0]   acc;
  logic signed [66:0]   res [7];
  logic                 vsel;
  logic [1:0]           comp;
  logic [66:0]          mag [3];
  logic [2:0]           negv;
  logic [63:0]          sumsq;
  logic [63:0]          sq_v;
  logic [63:0]          sq_r;
  logic [63:0]          sq_bit;
  logic [63:0]          rem;
  logic [63:0]          dsh;
  logic [31:0]          q;
  logic [15:0]          tv [3];
  logic [15:0]          bv [3];
  logic                 deg;
  logic [1:0]           slot;

  logic signed [32:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [65:0]   mul_res;
  logic [1:0]           mag_sel;
  logic [66:0]          mag_cur;
  logic [66:0]          ormag;
  logic [66:0]          load_mag [3];
  logic [2:0]           load_neg;
  logic                 is_deg;
  logic [63:0]          sq_t;
  logic [31:0]          len;
  logic [31:0]          qsat;
  logic [15:0]          oval;
  logic [3:0]           jm1;

  assign pop      = (state == S_IDLE) && !q_empty;
  assign m_tvalid = (state == S_EMIT);
  assign m_tdata  = {bv[2], bv[1], bv[0], tv[2], tv[1], tv[0]};
  assign m_tuser  = {slot, deg};
  assign m_tlast  = (slot == LAST_CORNER);

  assign mag_sel = (state == S_SQ) ? cnt[1:0] : comp;
  assign mag_cur = (mag_sel == 2'd3) ? '0 : mag[mag_sel];
  assign ormag   = mag[0] | mag[1] | mag[2];
  assign jm1     = 4'(cnt - 6'd1);
  assign sq_t    = sq_r + sq_bit;
  assign len     = sq_r[31:0];

  // Operand pairs: det, then tangent, then bitangent; odd steps are subtracted.
  always_comb begin
    logic [2:0] pair;
    logic       sec;
    logic [1:0] ti;
    logic [1:0] bi;
    pair  = cnt[3:1];
    sec   = cnt[0];
    ti    = 2'(pair - 3'd1);
    bi    = 2'(pair - 3'd4);
    mul_a = '0;
    mul_b = '0;
    if (state == S_SQ) begin
      mul_a = {3'b000, mag_cur[29:0]};
      mul_b = {3'b000, mag_cur[29:0]};
    end else begin
      case (pair)
        3'd0: begin
          mul_a = sec ? tri_r.x2 : tri_r.x1;
          mul_b = sec ? tri_r.y1 : tri_r.y2;
        end
        3'd1, 3'd2, 3'd3: begin
          mul_a = sec ? tri_r.e2[ti] : tri_r.e1[ti];
          mul_b = sec ? tri_r.y1 : tri_r.y2;
        end
        3'd4, 3'd5, 3'd6: begin
          mul_a = sec ? tri_r.e1[bi] : tri_r.e2[bi];
          mul_b = sec ? tri_r.x2 : tri_r.x1;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
    mul_res = mul_a * mul_b;
  end

  // Magnitudes of the selected vector; the sign is flipped when det is negative.
  always_comb begin
    logic signed [66:0] v;
    for (int i = 0; i < 3; i++) begin
      v           = vsel ? res[4 + i] : res[1 + i];
      load_mag[i] = v[66] ? 67'(-v) : v;
      load_neg[i] = v[66] ^ res[0][66];
    end
  end

  assign is_deg = (res[0] == '0)
               || (res[1] == '0 && res[2] == '0 && res[3] == '0)
               || (res[4] == '0 && res[5] == '0 && res[6] == '0);

  always_comb begin
    if (negv[comp]) begin
      qsat = (q > 32'd32768) ? 32'd32768 : q;
      oval = 16'(32'd0 - qsat);
    end else begin
      qsat = (q > 32'd32767) ? 32'd32767 : q;
      oval = qsat[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            tri_r <= q_head;
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt < 6'd14) begin
            prod <= mul_res;
          end
          if (cnt != 6'd0) begin
            if (!jm1[0]) begin
              acc <= prod;
            end else begin
              res[jm1[3:1]] <= 67'(acc) - 67'(prod);
            end
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd14) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          deg  <= is_deg;
          vsel <= 1'b0;
          if (is_deg) begin
            for (int i = 0; i < 3; i++) begin
              tv[i] <= '0;
              bv[i] <= '0;
            end
            slot  <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= load_mag[i];
          end
          negv  <= load_neg;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          // One bit a step until the largest magnitude sits in [2^29, 2^30).
          if (|ormag[66:30]) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else if (!ormag[29]) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] << 1;
            end
          end else begin
            sumsq <= '0;
            cnt   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt < 6'd3) begin
            prod <= mul_res;
          end
          if (cnt != 6'd0 && cnt != 6'd4) begin
            sumsq <= sumsq + 64'(prod[59:0]);
          end
          if (cnt == 6'd4) begin
            sq_v   <= sumsq;
            sq_r   <= '0;
            sq_bit <= 64'd1 << 62;
            cnt    <= '0;
            state  <= S_SQRT;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_SQRT: begin
          if (sq_v >= sq_t) begin
            sq_v <= sq_v - sq_t;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            comp  <= '0;
            state <= S_DINIT;
          end
        end
        S_DINIT: begin
          rem   <= (64'(mag_cur[29:0]) << OUT_FRAC_BITS) + 64'(len >> 1);
          dsh   <= 64'(len) << (QW - 1);
          q     <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            q   <= {q[30:0], 1'b1};
          end else begin
            q   <= {q[30:0], 1'b0};
          end
          dsh <= dsh >> 1;
          cnt <= cnt + 6'd1;
          if (cnt == 6'(QW - 1)) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          if (!vsel) begin
            tv[comp] <= oval;
          end else begin
            bv[comp] <= oval;
          end
          if (comp == 2'd2) begin
            if (!vsel) begin
              vsel  <= 1'b1;
              state <= S_LOAD;
            end else begin
              slot  <= '0;
              state <= S_EMIT;
            end
          end else begin
            comp  <= comp + 2'd1;
            state <= S_DINIT;
          end
        end
        S_EMIT: begin
          if (m_tready) begin
            if (slot == LAST_CORNER) begin
              state <= S_IDLE;
            end else begin
              slot <= slot + 2'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && deg |-> (m_tdata == '0))
    else $error("degenerate result carries nonzero vectors");
  a_slot_step: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tready && slot != LAST_CORNER |=>
      m_tvalid && slot == $past(slot) + 2'd1)
    else $error("corner slot did not advance");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
      pop |=> state == S_MUL && cnt == 6'd0)
    else $error("triangle taken without starting the product pass");

endmodule
